FILE: src/pfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_pkg
// Shared types, codes and widths of the polyline path follower.
// ----------------------------------------------------------------------------
package pfl_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned IdxWDef      = $clog2(MaxPointsDef);

  localparam int unsigned CoordW = 16;             // signed Q8.8 coordinate
  localparam int unsigned DistW  = 17;             // unsigned Q9.8 distance
  localparam int unsigned OffW   = 18;             // cursor offset
  localparam int unsigned LenW   = 17;             // segment length
  localparam int unsigned SqW    = 34;             // dx^2 + dy^2
  localparam int unsigned RootW  = 35;             // root accumulator
  localparam int unsigned QuoW   = 16;             // interpolation quotient
  localparam int unsigned MulW   = 18;             // signed multiplier operand

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_START   = 2'd2,
    OP_ADVANCE = 2'd3
  } pfl_op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } pfl_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQRT,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_OUT_SEL,
    ST_P0,
    ST_P1,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } pfl_state_e;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic clear;
    logic set_full;
    logic wr_point;
    logic sq_x;
    logic sq_y;
    logic sqrt_step;
    logic start_init;
    logic adv_init;
    logic walk_rd;
    logic walk_step;
    logic walk_end;
    logic rd_p0;
    logic lat_p0;
    logic rd_p1;
    logic lat_p1;
    logic mul;
    logic div_step;
    logic load_out;
  } pfl_cmd_t;

  typedef struct packed {
    logic    in_valid;
    logic    out_busy;
    pfl_op_e op;
    logic    count_zero;
    logic    full;
    logic    at_end;
    logic    off_ge_len;
    logic    len_zero;
    logic    sqrt_last;
    logic    div_last;
    logic    axis_y;
  } pfl_stat_t;

endpackage

FILE: src/pfl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_in_if
// Command channel of the path follower: valid/ready plus command payload.
// ----------------------------------------------------------------------------
interface pfl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic [16:0]        distance;

  modport source (output valid, command, point_x, point_y, distance, input ready);
  modport sink   (input valid, command, point_x, point_y, distance, output ready);
endinterface

FILE: src/pfl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_out_if
// Result channel of the path follower: valid/ready plus position payload.
// ----------------------------------------------------------------------------
interface pfl_out_if #(
  parameter int unsigned IdxW = pfl_pkg::IdxWDef
);
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [IdxW-1:0]    segment_index;
  logic               reached_end;
  logic [1:0]         status;

  modport source (output valid, pos_x, pos_y, segment_index, reached_end, status,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, segment_index, reached_end, status,
                  output ready);
endinterface

FILE: src/pfl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfl_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: src/pfl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_ctrl
// Sequencer of the path follower: steps the datapath through append, walk
// and interpolation for one command at a time.
// ----------------------------------------------------------------------------
module pfl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfl_pkg::pfl_stat_t  stat_i,
  output pfl_pkg::pfl_cmd_t   cmd_o
);

  pfl_pkg::pfl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      pfl_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.capture = 1'b1;
          state_d       = pfl_pkg::ST_DECODE;
        end
      end
      pfl_pkg::ST_DECODE: begin
        case (stat_i.op)
          pfl_pkg::OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            state_d     = pfl_pkg::ST_OUT_SEL;
          end
          pfl_pkg::OP_APPEND: begin
            if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
              state_d        = pfl_pkg::ST_OUT_SEL;
            end else begin
              // also fetches the previous point
              cmd_o.wr_point = 1'b1;
              state_d = stat_i.count_zero ? pfl_pkg::ST_OUT_SEL : pfl_pkg::ST_SQ_X;
            end
          end
          pfl_pkg::OP_START: begin
            if (stat_i.count_zero) begin
              state_d = pfl_pkg::ST_OUT_SEL;
            end else begin
              cmd_o.start_init = 1'b1;
              state_d          = pfl_pkg::ST_WALK_RD;
            end
          end
          default: begin
            if (stat_i.count_zero) begin
              state_d = pfl_pkg::ST_OUT_SEL;
            end else begin
              cmd_o.adv_init = 1'b1;
              state_d        = pfl_pkg::ST_WALK_RD;
            end
          end
        endcase
      end
      pfl_pkg::ST_SQ_X: begin
        cmd_o.sq_x = 1'b1;
        state_d    = pfl_pkg::ST_SQ_Y;
      end
      pfl_pkg::ST_SQ_Y: begin
        cmd_o.sq_y = 1'b1;
        state_d    = pfl_pkg::ST_SQRT;
      end
      pfl_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (stat_i.sqrt_last) begin
          state_d = pfl_pkg::ST_OUT_SEL;
        end
      end
      pfl_pkg::ST_WALK_RD: begin
        if (stat_i.at_end) begin
          cmd_o.walk_end = 1'b1;
          state_d        = pfl_pkg::ST_OUT_SEL;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = pfl_pkg::ST_WALK_CHK;
        end
      end
      pfl_pkg::ST_WALK_CHK: begin
        if (stat_i.off_ge_len) begin
          cmd_o.walk_step = 1'b1;
          state_d         = pfl_pkg::ST_WALK_RD;
        end else begin
          state_d = pfl_pkg::ST_OUT_SEL;
        end
      end
      pfl_pkg::ST_OUT_SEL: begin
        if (stat_i.count_zero) begin
          state_d = pfl_pkg::ST_LOAD;
        end else begin
          cmd_o.rd_p0 = 1'b1;
          state_d     = pfl_pkg::ST_P0;
        end
      end
      pfl_pkg::ST_P0: begin
        cmd_o.lat_p0 = 1'b1;
        if (stat_i.at_end || stat_i.len_zero) begin
          state_d = pfl_pkg::ST_LOAD;
        end else begin
          cmd_o.rd_p1 = 1'b1;
          state_d     = pfl_pkg::ST_P1;
        end
      end
      pfl_pkg::ST_P1: begin
        cmd_o.lat_p1 = 1'b1;
        state_d      = pfl_pkg::ST_MUL;
      end
      pfl_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = pfl_pkg::ST_DIV;
      end
      pfl_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = stat_i.axis_y ? pfl_pkg::ST_LOAD : pfl_pkg::ST_MUL;
        end
      end
      pfl_pkg::ST_LOAD: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = pfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/pfl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfl_datapath
// Checkpoint tables, cursor, shared multiplier, root and divide units and
// the output register of the path follower.
// ----------------------------------------------------------------------------
module pfl_datapath #(
  parameter int unsigned MaxPoints = pfl_pkg::MaxPointsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pfl_in_if.sink             in_i,
  pfl_out_if.source          out_o,
  input  pfl_pkg::pfl_cmd_t  cmd_i,
  output pfl_pkg::pfl_stat_t stat_o
);

  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned CW   = pfl_pkg::CoordW;
  localparam int unsigned DivCntW = $clog2(pfl_pkg::QuoW);

  // captured item
  logic [1:0]                     op_q;
  logic signed [CW-1:0]           px_q, py_q;
  logic [pfl_pkg::DistW-1:0]      dist_q;

  // cursor and table fill
  logic [CntW-1:0]                count_q;
  logic [IdxW-1:0]                seg_q;
  logic [pfl_pkg::OffW-1:0]       off_q;

  logic signed [CW-1:0]           p0x_q, p0y_q, p1x_q, p1y_q;
  logic [pfl_pkg::LenW-1:0]       len_q;
  logic [1:0]                     status_q;
  logic                           axis_q;

  logic [pfl_pkg::SqW-1:0]        acc_q, v_q;
  logic [pfl_pkg::RootW-1:0]      res_q, bit_q;
  logic [pfl_pkg::LenW-1:0]       rem_q;
  logic [pfl_pkg::QuoW-1:0]       lo_q, quo_q;
  logic [DivCntW-1:0]             div_cnt_q;
  logic signed [CW-1:0]           posx_q, posy_q;

  logic                           out_valid_q;
  logic signed [CW-1:0]           out_x_q, out_y_q;
  logic [IdxW-1:0]                out_seg_q;
  logic                           out_end_q;
  logic [1:0]                     out_stat_q;

  // ---------------------------------------------------------------- RAMs
  logic [IdxW-1:0]                last_idx;
  logic                           pt_re;
  logic [IdxW-1:0]                pt_raddr;
  logic [2*CW-1:0]                pt_rdata;
  logic                           len_we, len_re;
  logic [pfl_pkg::LenW-1:0]       len_rdata;
  logic                           count_zero, at_end;

  assign last_idx   = IdxW'(count_q - CntW'(1));
  assign count_zero = (count_q == '0);
  assign at_end     = (CntW'(seg_q) >= (count_q - CntW'(1)));

  assign pt_re = cmd_i.wr_point | cmd_i.rd_p0 | cmd_i.rd_p1;
  always_comb begin
    if (cmd_i.rd_p1) begin
      pt_raddr = seg_q + IdxW'(1);
    end else if (cmd_i.rd_p0) begin
      pt_raddr = at_end ? last_idx : seg_q;
    end else begin
      pt_raddr = last_idx;
    end
  end

  pfl_ram #(.Width(2 * CW), .Depth(MaxPoints)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_point),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({px_q, py_q}),
    .re_i    (pt_re),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  assign len_we = cmd_i.sqrt_step & bit_q[0];
  assign len_re = cmd_i.walk_rd | cmd_i.rd_p0;

  // ---------------------------------------------------------------- root
  logic [pfl_pkg::RootW-1:0]      root_sum, root_nx;
  logic                           root_ge;

  assign root_sum = res_q + bit_q;
  assign root_ge  = ({1'b0, v_q} >= root_sum);
  assign root_nx  = root_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

  pfl_ram #(.Width(pfl_pkg::LenW), .Depth(MaxPoints)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (last_idx),
    .wdata_i (root_nx[pfl_pkg::LenW-1:0]),
    .re_i    (len_re),
    .raddr_i (seg_q),
    .rdata_o (len_rdata)
  );

  // ---------------------------------------------------------- multiplier
  logic signed [CW:0]             prev_x, prev_y, dx, dy;
  logic signed [CW-1:0]           a0, a1;
  logic signed [CW:0]             delta, mag_full;
  logic                           neg;
  logic [CW-1:0]                  mag;
  logic signed [pfl_pkg::MulW-1:0]   mul_a, mul_b;
  logic signed [2*pfl_pkg::MulW-1:0] prod;
  logic [pfl_pkg::SqW-1:0]        prod_u;

  assign prev_x = {pt_rdata[2*CW-1], pt_rdata[2*CW-1:CW]};
  assign prev_y = {pt_rdata[CW-1], pt_rdata[CW-1:0]};
  assign dx     = {px_q[CW-1], px_q} - prev_x;
  assign dy     = {py_q[CW-1], py_q} - prev_y;

  assign a0       = axis_q ? p0y_q : p0x_q;
  assign a1       = axis_q ? p1y_q : p1x_q;
  assign delta    = {a1[CW-1], a1} - {a0[CW-1], a0};
  assign neg      = delta[CW];
  assign mag_full = neg ? -delta : delta;
  assign mag      = mag_full[CW-1:0];

  always_comb begin
    if (cmd_i.sq_x) begin
      mul_a = {dx[CW], dx};
      mul_b = {dx[CW], dx};
    end else if (cmd_i.sq_y) begin
      mul_a = {dy[CW], dy};
      mul_b = {dy[CW], dy};
    end else begin
      mul_a = {1'b0, off_q[pfl_pkg::LenW-1:0]};
      mul_b = {2'b00, mag};
    end
  end

  assign prod   = mul_a * mul_b;
  assign prod_u = prod[pfl_pkg::SqW-1:0];

  // -------------------------------------------------------------- divider
  logic [pfl_pkg::LenW:0]         trial, trial_sub;
  logic                           qb;
  logic [pfl_pkg::QuoW-1:0]       quo_nx;
  logic signed [CW-1:0]           lerp;

  assign trial     = {rem_q, lo_q[pfl_pkg::QuoW-1]};
  assign qb        = (trial >= {1'b0, len_q});
  assign trial_sub = trial - {1'b0, len_q};
  assign quo_nx    = {quo_q[pfl_pkg::QuoW-2:0], qb};
  assign lerp      = neg ? (a0 - $signed(quo_nx)) : (a0 + $signed(quo_nx));

  // ------------------------------------------------------ control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      seg_q       <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
        seg_q   <= '0;
        off_q   <= '0;
      end
      if (cmd_i.wr_point && count_zero) begin
        count_q <= CntW'(1);
      end
      if (len_we) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.start_init) begin
        seg_q <= '0;
        off_q <= {1'b0, dist_q};
      end
      if (cmd_i.adv_init) begin
        off_q <= off_q + {1'b0, dist_q};
      end
      if (cmd_i.walk_step) begin
        seg_q <= seg_q + IdxW'(1);
        off_q <= off_q - {1'b0, len_rdata};
      end
      if (cmd_i.walk_end) begin
        off_q <= '0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= in_i.command;
      px_q     <= in_i.point_x;
      py_q     <= in_i.point_y;
      dist_q   <= in_i.distance;
      status_q <= pfl_pkg::STAT_OK;
    end
    if (cmd_i.set_full) begin
      status_q <= pfl_pkg::STAT_FULL;
    end
    if (cmd_i.sq_x) begin
      acc_q <= prod_u;
    end
    if (cmd_i.sq_y) begin
      v_q   <= acc_q + prod_u;
      res_q <= '0;
      bit_q <= pfl_pkg::RootW'(1) << (pfl_pkg::SqW - 2);
    end
    if (cmd_i.sqrt_step) begin
      if (root_ge) begin
        v_q <= v_q - root_sum[pfl_pkg::SqW-1:0];
      end
      res_q <= root_nx;
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.lat_p0) begin
      p0x_q  <= pt_rdata[2*CW-1:CW];
      p0y_q  <= pt_rdata[CW-1:0];
      posx_q <= pt_rdata[2*CW-1:CW];
      posy_q <= pt_rdata[CW-1:0];
      len_q  <= len_rdata;
      axis_q <= 1'b0;
    end
    if (cmd_i.lat_p1) begin
      p1x_q <= pt_rdata[2*CW-1:CW];
      p1y_q <= pt_rdata[CW-1:0];
    end
    if (cmd_i.mul) begin
      // quotient fits in 16 bits, so the high part is already below len
      rem_q     <= prod_u[pfl_pkg::LenW+pfl_pkg::QuoW-1:pfl_pkg::QuoW];
      lo_q      <= prod_u[pfl_pkg::QuoW-1:0];
      quo_q     <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q     <= qb ? trial_sub[pfl_pkg::LenW-1:0] : trial[pfl_pkg::LenW-1:0];
      lo_q      <= lo_q << 1;
      quo_q     <= quo_nx;
      div_cnt_q <= div_cnt_q + DivCntW'(1);
      if (div_cnt_q == '1) begin
        if (axis_q) begin
          posy_q <= lerp;
        end else begin
          posx_q <= lerp;
        end
        axis_q <= ~axis_q;
      end
    end
    if (cmd_i.load_out) begin
      out_x_q    <= count_zero ? '0 : posx_q;
      out_y_q    <= count_zero ? '0 : posy_q;
      out_seg_q  <= seg_q;
      out_end_q  <= count_zero | at_end;
      out_stat_q <= count_zero ? pfl_pkg::STAT_EMPTY : status_q;
    end
  end

  // ------------------------------------------------------------- status
  always_comb begin
    stat_o            = '0;
    stat_o.in_valid   = in_i.valid;
    stat_o.out_busy   = out_valid_q & ~out_o.ready;
    stat_o.op         = pfl_pkg::pfl_op_e'(op_q);
    stat_o.count_zero = count_zero;
    stat_o.full       = (count_q == CntW'(MaxPoints));
    stat_o.at_end     = at_end;
    stat_o.off_ge_len = (off_q >= {1'b0, len_rdata});
    stat_o.len_zero   = (len_rdata == '0);
    stat_o.sqrt_last  = bit_q[0];
    stat_o.div_last   = (div_cnt_q == '1);
    stat_o.axis_y     = axis_q;
  end

  assign in_i.ready          = cmd_i.in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.pos_x         = out_x_q;
  assign out_o.pos_y         = out_y_q;
  assign out_o.segment_index = out_seg_q;
  assign out_o.reached_end   = out_end_q;
  assign out_o.status        = out_stat_q;

endmodule

FILE: src/polyline_path_follower_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_path_follower_unit
// Checkpoint path with arc-length cursor and interpolated position output.
// ----------------------------------------------------------------------------
// Usage: commands enter on in_i (valid/ready); every accepted beat yields one
// result beat on out_o. Commands: clear path, append point (stores the point
// and the root-length of the segment it closes), start at distance, advance
// by distance. The result carries the interpolated position, the segment
// index, the end flag and a status code.
// One command is in flight at a time. Clear and an empty path go straight to
// the result; otherwise the position is read from the stored points. An
// append first adds two squares and a 17-step bit-serial root; start and
// advance walk the cursor segment by segment, and a position inside a
// segment takes one shared multiply and a 16-step restoring divide per axis.
// A new command can be taken from the cycle after the result is loaded, so
// none is taken before the last one is through.
// Reset empties the path and parks the cursor at zero; table contents are
// left as they are, and an unwritten entry may be read but is never used.
// The result sits in an output register; a new command is taken while it
// waits, and the next result holds in its final state until out_o is free.
// ----------------------------------------------------------------------------
module polyline_path_follower_unit #(
  parameter int unsigned MaxPoints = pfl_pkg::MaxPointsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfl_in_if.sink    in_i,
  pfl_out_if.source out_o
);

  pfl_pkg::pfl_cmd_t  cmd;
  pfl_pkg::pfl_stat_t stat;

  pfl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  pfl_datapath #(.MaxPoints(MaxPoints)) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // busy after taking a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("accepted a second command back to back");

  // never overwrite a result still waiting on the sink
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_o.valid && !out_o.ready))
    else $error("result register overwritten while stalled");

  // empty path reports the origin at the end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == pfl_pkg::STAT_EMPTY |->
      out_o.reached_end && out_o.pos_x == '0 && out_o.pos_y == '0)
    else $error("empty path result malformed");

endmodule
